// ===== design/bchd_pkg.sv =====
package bchd_pkg;

   // Payload widths
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 24;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned CountWidth   = 8;
   localparam int unsigned LimitWidth   = 16;

   // Register indexes
   localparam logic [CsrAddrWidth-1:0] RegDebounce = 3'd0;
   localparam logic [CsrAddrWidth-1:0] RegHold     = 3'd1;
   localparam logic [CsrAddrWidth-1:0] RegClick    = 3'd2;
   localparam logic [CsrAddrWidth-1:0] RegStep     = 3'd3;
   localparam logic [CsrAddrWidth-1:0] RegInvert   = 3'd4;

   // Register reset values
   localparam logic [LimitWidth-1:0] DebounceReset = 16'd60;
   localparam logic [LimitWidth-1:0] HoldReset     = 16'd500;
   localparam logic [LimitWidth-1:0] ClickReset    = 16'd500;
   localparam logic [LimitWidth-1:0] StepReset     = 16'd400;

   localparam logic [CountWidth-1:0] CountMax = 8'hFF;

   // Acknowledge mask bits
   localparam int unsigned AckPress   = 0;
   localparam int unsigned AckRelease = 1;
   localparam int unsigned AckClick   = 2;
   localparam int unsigned AckHeld    = 3;
   localparam int unsigned AckCount   = 4;

   // Elapsed time against a limit. When the mark was moved to now in this
   // tick the elapsed time is zero, so only a zero limit is reached.
   function automatic logic time_reached(input logic                  mark_now,
                                         input logic [TimeWidth-1:0]  elapsed,
                                         input logic [LimitWidth-1:0] limit);
      logic result;
      if (mark_now) begin
         result = (limit == '0);
      end else begin
         result = (elapsed >= {{(TimeWidth-LimitWidth){1'b0}}, limit});
      end
      return result;
   endfunction

endpackage

// ===== design/button_click_hold_detector_top.sv =====
// Each accepted item waits in the input register until the result slot is free
// or its result is taken; one pass of tick logic then writes its result into
// the result register. Each item gives exactly one result.
// Throughput: one item per cycle while the receiver keeps taking results, set
// by the single pass of tick logic between the input register and the result register.
// Reset: synchronous, active high; clears all button state and loads the
// register defaults (60, 500, 500, 400 ms, no inversion).
module button_click_hold_detector_top import bchd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // raw_level[0], now_ms[32:1], ack_mask[37:33], step_query[38],
   // step_clicks[46:39], clear_all[47]
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // pressed[0], press_event[1], release_event[2], click_event[3],
   // held_event[4], holding[5], count_ready[6], click_count[14:7],
   // hold_clicks[22:15], step_fire[23]
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   // Configuration registers
   logic [LimitWidth-1:0] debounce_ff;
   logic [LimitWidth-1:0] hold_to_ff;
   logic [LimitWidth-1:0] click_to_ff;
   logic [LimitWidth-1:0] step_to_ff;
   logic                  invert_ff;

   // Channel registers
   logic                    req_valid_ff, req_valid_in;
   logic [ReqDataWidth-1:0] req_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic                    advance;

   // Button state
   logic                  acc_ff, acc_in;
   logic                  dbr_ff, dbr_in;
   logic [TimeWidth-1:0]  mark_ff, mark_in;
   logic                  press_ff, press_in;
   logic                  release_ff, release_in;
   logic                  click_ff, click_in;
   logic                  held_ff, held_in;
   logic                  count_ff, count_in;
   logic                  step_ff, step_in;
   logic                  hold_ff, hold_in;
   logic                  armed_ff, armed_in;
   logic [CountWidth-1:0] series_ff, series_in;
   logic [CountWidth-1:0] finished_ff, finished_in;
   logic [CountWidth-1:0] cbh_ff, cbh_in;

   // Unpacked fields of the held item
   logic                  raw_level;
   logic [TimeWidth-1:0]  now_ms;
   logic [4:0]            ack_mask;
   logic                  step_query;
   logic [CountWidth-1:0] step_clicks;
   logic                  clear_all;

   // Tick intermediates
   logic                  level;
   logic [TimeWidth-1:0]  elapsed;
   logic                  mark_now;
   logic                  fire;
   logic [CountWidth-1:0] hold_clicks;

   assign raw_level   = req_data_ff[0];
   assign now_ms      = req_data_ff[32:1];
   assign ack_mask    = req_data_ff[37:33];
   assign step_query  = req_data_ff[38];
   assign step_clicks = req_data_ff[46:39];
   assign clear_all   = req_data_ff[47];

   // Handshake: the held item moves on when the result slot is free or its result is taken
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // One tick of the detector
   always_comb begin
      acc_in      = acc_ff;
      dbr_in      = dbr_ff;
      mark_in     = mark_ff;
      press_in    = press_ff;
      release_in  = release_ff;
      click_in    = click_ff;
      held_in     = held_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      hold_in     = hold_ff;
      armed_in    = armed_ff;
      series_in   = series_ff;
      finished_in = finished_ff;
      cbh_in      = cbh_ff;
      fire        = 1'b0;
      mark_now    = 1'b0;

      level   = raw_level ^ invert_ff;
      elapsed = now_ms - mark_ff;

      // debounce of a press
      if (level && !acc_ff) begin
         if (!dbr_ff) begin
            dbr_in   = 1'b1;
            mark_in  = now_ms;
            mark_now = 1'b1;
         end else if (elapsed >= {{(TimeWidth-LimitWidth){1'b0}}, debounce_ff}) begin
            acc_in   = 1'b1;
            press_in = 1'b1;
            armed_in = 1'b1;
         end
      end else begin
         dbr_in = 1'b0;
      end

      // release
      if (!level && acc_ff) begin
         acc_in = 1'b0;
         if (!hold_ff && series_ff != CountMax) begin
            series_in = series_ff + 1'b1;
         end
         hold_in    = 1'b0;
         release_in = 1'b1;
         mark_in    = now_ms;
         mark_now   = 1'b1;
         if (step_ff) begin
            finished_in = '0;
            series_in   = '0;
            step_in     = 1'b0;
         end
         if (armed_in) begin
            armed_in = 1'b0;
            click_in = 1'b1;
         end
      end

      // hold; the mark moves to now on this path
      if (acc_in && level && !hold_in &&
          elapsed >= {{(TimeWidth-LimitWidth){1'b0}}, hold_to_ff}) begin
         hold_in  = 1'b1;
         held_in  = 1'b1;
         step_in  = 1'b1;
         armed_in = 1'b0;
         cbh_in   = series_in;
         mark_in  = now_ms;
         mark_now = 1'b1;
      end

      // click series closes
      if (time_reached(mark_now, elapsed, click_to_ff) && series_in != '0) begin
         finished_in = series_in;
         series_in   = '0;
         count_in    = 1'b1;
      end

      // step query
      if (step_query && series_in == step_clicks && step_in &&
          time_reached(mark_now, elapsed, step_to_ff)) begin
         mark_in = now_ms;
         fire    = 1'b1;
      end

      hold_clicks = hold_in ? cbh_in : '0;
      rsp_data_in = {fire, hold_clicks, finished_in, count_in, step_in, held_in,
                     click_in, release_in, press_in, level};

      // acknowledges and clear after the result is formed
      if (ack_mask[AckPress])   press_in   = 1'b0;
      if (ack_mask[AckRelease]) release_in = 1'b0;
      if (ack_mask[AckClick])   click_in   = 1'b0;
      if (ack_mask[AckHeld])    held_in    = 1'b0;
      if (ack_mask[AckCount]) begin
         count_in    = 1'b0;
         finished_in = '0;
      end
      if (clear_all) begin
         press_in    = 1'b0;
         release_in  = 1'b0;
         click_in    = 1'b0;
         held_in     = 1'b0;
         step_in     = 1'b0;
         count_in    = 1'b0;
         cbh_in      = '0;
         finished_in = '0;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DebounceReset;
         hold_to_ff  <= HoldReset;
         click_to_ff <= ClickReset;
         step_to_ff  <= StepReset;
         invert_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            RegDebounce: begin
               debounce_ff <= csr_wdata;
            end
            RegHold: begin
               hold_to_ff <= csr_wdata;
            end
            RegClick: begin
               click_to_ff <= csr_wdata;
            end
            RegStep: begin
               step_to_ff <= csr_wdata;
            end
            RegInvert: begin
               invert_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Channel control
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Button state, updated once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= 1'b0;
         dbr_ff      <= 1'b0;
         mark_ff     <= '0;
         press_ff    <= 1'b0;
         release_ff  <= 1'b0;
         click_ff    <= 1'b0;
         held_ff     <= 1'b0;
         count_ff    <= 1'b0;
         step_ff     <= 1'b0;
         hold_ff     <= 1'b0;
         armed_ff    <= 1'b0;
         series_ff   <= '0;
         finished_ff <= '0;
         cbh_ff      <= '0;
      end else if (advance) begin
         acc_ff      <= acc_in;
         dbr_ff      <= dbr_in;
         mark_ff     <= mark_in;
         press_ff    <= press_in;
         release_ff  <= release_in;
         click_ff    <= click_in;
         held_ff     <= held_in;
         count_ff    <= count_in;
         step_ff     <= step_in;
         hold_ff     <= hold_in;
         armed_ff    <= armed_in;
         series_ff   <= series_in;
         finished_ff <= finished_in;
         cbh_ff      <= cbh_in;
      end
   end

endmodule

// ===== verif/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bchd_pkg::*;

   // One tick in, lowest field last in declaration order
   typedef struct packed {
      logic                  clear_all;
      logic [CountWidth-1:0] step_clicks;
      logic                  step_query;
      logic [4:0]            ack_mask;
      logic [TimeWidth-1:0]  now_ms;
      logic                  raw_level;
   } tick_type;

   // One status word out
   typedef struct packed {
      logic                  step_fire;
      logic [CountWidth-1:0] hold_clicks;
      logic [CountWidth-1:0] click_count;
      logic                  count_ready;
      logic                  holding;
      logic                  held_event;
      logic                  click_event;
      logic                  release_event;
      logic                  press_event;
      logic                  pressed;
   } status_type;

   // Bits of the internal flag byte
   localparam int unsigned FlagPress   = 0;
   localparam int unsigned FlagRelease = 1;
   localparam int unsigned FlagClick   = 2;
   localparam int unsigned FlagHeld    = 3;
   localparam int unsigned FlagCount   = 4;
   localparam int unsigned FlagStep    = 5;
   localparam int unsigned FlagHold    = 6;
   localparam int unsigned FlagArmed   = 7;

   localparam int unsigned StallLimit  = 2000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_we = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   button_click_hold_detector_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Register copies, start at the reset defaults
   logic [LimitWidth-1:0] deb_cfg   = DebounceReset;
   logic [LimitWidth-1:0] hold_cfg  = HoldReset;
   logic [LimitWidth-1:0] click_cfg = ClickReset;
   logic [LimitWidth-1:0] step_cfg  = StepReset;
   logic                  inv_cfg   = 1'b0;

   // Button state copy
   logic                  level       = 1'b0;
   logic                  accepted    = 1'b0;
   logic                  debouncing  = 1'b0;
   logic [TimeWidth-1:0]  mark_ms     = '0;
   logic [7:0]            flags       = '0;
   logic [CountWidth-1:0] series      = '0;
   logic [CountWidth-1:0] finished    = '0;
   logic [CountWidth-1:0] before_hold = '0;

   tick_type   pending_ticks[$];
   status_type expected_status[$];

   int unsigned          send_idle = 0;
   int unsigned          recv_idle = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          status_seen = 0;
   int unsigned          stall_cycles = 0;
   logic [TimeWidth-1:0] cur_ms = '0;

   function automatic logic limit_reached(input logic [TimeWidth-1:0]  now_ms,
                                          input logic [LimitWidth-1:0] limit_ms);
      logic [TimeWidth-1:0] gap;
      gap = now_ms - mark_ms;
      return gap >= {{(TimeWidth-LimitWidth){1'b0}}, limit_ms};
   endfunction

   // Advance the button state by one tick and give the status it shows
   function automatic status_type predict_button_tick(input tick_type t);
      status_type s;
      logic       fire;
      fire  = 1'b0;
      level = t.raw_level ^ inv_cfg;

      // debounce of a new press
      if (level && !accepted) begin
         if (!debouncing) begin
            debouncing = 1'b1;
            mark_ms    = t.now_ms;
         end else if (limit_reached(t.now_ms, deb_cfg)) begin
            accepted         = 1'b1;
            flags[FlagPress] = 1'b1;
            flags[FlagArmed] = 1'b1;
         end
      end else begin
         debouncing = 1'b0;
      end

      // release of an accepted press
      if (!level && accepted) begin
         accepted = 1'b0;
         if (!flags[FlagHold] && series < CountMax) begin
            series = series + 1'b1;
         end
         flags[FlagHold]    = 1'b0;
         flags[FlagRelease] = 1'b1;
         mark_ms            = t.now_ms;
         if (flags[FlagStep]) begin
            finished        = '0;
            series          = '0;
            flags[FlagStep] = 1'b0;
         end
         if (flags[FlagArmed]) begin
            flags[FlagArmed] = 1'b0;
            flags[FlagClick] = 1'b1;
         end
      end

      // hold timeout
      if (accepted && level && !flags[FlagHold] && limit_reached(t.now_ms, hold_cfg)) begin
         flags[FlagHold]  = 1'b1;
         flags[FlagHeld]  = 1'b1;
         flags[FlagStep]  = 1'b1;
         flags[FlagArmed] = 1'b0;
         before_hold      = series;
         mark_ms          = t.now_ms;
      end

      // click series closes after the idle timeout
      if (limit_reached(t.now_ms, click_cfg) && series != '0) begin
         finished         = series;
         series           = '0;
         flags[FlagCount] = 1'b1;
      end

      // step pulse
      if (t.step_query && series == t.step_clicks && flags[FlagStep] &&
          limit_reached(t.now_ms, step_cfg)) begin
         mark_ms = t.now_ms;
         fire    = 1'b1;
      end

      s.pressed       = level;
      s.press_event   = flags[FlagPress];
      s.release_event = flags[FlagRelease];
      s.click_event   = flags[FlagClick];
      s.held_event    = flags[FlagHeld];
      s.holding       = flags[FlagStep];
      s.count_ready   = flags[FlagCount];
      s.click_count   = finished;
      s.hold_clicks   = flags[FlagHold] ? before_hold : '0;
      s.step_fire     = fire;

      // clears take effect after the status is formed
      if (t.ack_mask[AckPress])   flags[FlagPress]   = 1'b0;
      if (t.ack_mask[AckRelease]) flags[FlagRelease] = 1'b0;
      if (t.ack_mask[AckClick])   flags[FlagClick]   = 1'b0;
      if (t.ack_mask[AckHeld])    flags[FlagHeld]    = 1'b0;
      if (t.ack_mask[AckCount]) begin
         flags[FlagCount] = 1'b0;
         finished         = '0;
      end
      if (t.clear_all) begin
         flags[FlagPress]   = 1'b0;
         flags[FlagRelease] = 1'b0;
         flags[FlagClick]   = 1'b0;
         flags[FlagHeld]    = 1'b0;
         flags[FlagStep]    = 1'b0;
         flags[FlagCount]   = 1'b0;
         before_hold        = '0;
         finished           = '0;
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("status %0d: %s got %0h, expected %0h", status_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_status(input status_type got, input status_type want);
      if (got.pressed !== want.pressed)
         report_mismatch("pressed", 32'(got.pressed), 32'(want.pressed));
      if (got.press_event !== want.press_event)
         report_mismatch("press_event", 32'(got.press_event), 32'(want.press_event));
      if (got.release_event !== want.release_event)
         report_mismatch("release_event", 32'(got.release_event),
                         32'(want.release_event));
      if (got.click_event !== want.click_event)
         report_mismatch("click_event", 32'(got.click_event), 32'(want.click_event));
      if (got.held_event !== want.held_event)
         report_mismatch("held_event", 32'(got.held_event), 32'(want.held_event));
      if (got.holding !== want.holding)
         report_mismatch("holding", 32'(got.holding), 32'(want.holding));
      if (got.count_ready !== want.count_ready)
         report_mismatch("count_ready", 32'(got.count_ready), 32'(want.count_ready));
      if (got.click_count !== want.click_count)
         report_mismatch("click_count", 32'(got.click_count), 32'(want.click_count));
      if (got.hold_clicks !== want.hold_clicks)
         report_mismatch("hold_clicks", 32'(got.hold_clicks), 32'(want.hold_clicks));
      if (got.step_fire !== want.step_fire)
         report_mismatch("step_fire", 32'(got.step_fire), 32'(want.step_fire));
   endtask

   // Driver: predicts each item as it is accepted, then offers the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(predict_button_tick(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               req_tdata  <= pending_ticks.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each status with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected status", 32'(rsp_tdata), '0);
            end else begin
               check_status(rsp_tdata, expected_status.pop_front());
            end
            status_seen++;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Register write, also updates the predictor's copy
   task automatic write_csr(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         RegDebounce: deb_cfg   = data;
         RegHold:     hold_cfg  = data;
         RegClick:    click_cfg = data;
         RegStep:     step_cfg  = data;
         RegInvert:   inv_cfg   = data[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CsrDataWidth-1:0] deb, input logic [CsrDataWidth-1:0] hold,
                            input logic [CsrDataWidth-1:0] click,
                            input logic [CsrDataWidth-1:0] step,
                            input logic [CsrDataWidth-1:0] inv);
      write_csr(RegDebounce, deb);
      write_csr(RegHold, hold);
      write_csr(RegClick, click);
      write_csr(RegStep, step);
      write_csr(RegInvert, inv);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Tick with a logical level and random side fields
   task automatic push_tick(input logic pressed_lvl);
      tick_type t;
      t.raw_level   = pressed_lvl ^ inv_cfg;
      t.now_ms      = cur_ms;
      t.ack_mask    = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'h0;
      t.step_query  = 1'($urandom_range(0, 1));
      t.step_clicks = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      t.clear_all   = ($urandom_range(0, 29) == 0);
      pending_ticks.push_back(t);
   endtask

   task automatic dir_tick(input logic pressed_lvl, input int unsigned dt, input logic [4:0] ack,
                           input logic query, input logic [7:0] want, input logic clr);
      tick_type t;
      cur_ms        = cur_ms + dt;
      t.raw_level   = pressed_lvl ^ inv_cfg;
      t.now_ms      = cur_ms;
      t.ack_mask    = ack;
      t.step_query  = query;
      t.step_clicks = want;
      t.clear_all   = clr;
      pending_ticks.push_back(t);
   endtask

   // A stretch of one level over span_ms, with the odd bounce
   task automatic push_level(input logic pressed_lvl, input int unsigned span_ms,
                             inout int unsigned made);
      int unsigned ticks;
      int unsigned spacing;
      ticks   = $urandom_range(2, 8);
      spacing = span_ms / ticks;
      for (int unsigned i = 0; i < ticks; i++) begin
         cur_ms = cur_ms + spacing + $urandom_range(0, 1);
         push_tick(pressed_lvl ^ ($urandom_range(0, 19) == 0));
         made++;
      end
   endtask

   // Press and release sessions scaled to the current timeouts, plus noise
   task automatic gen_sessions(input int unsigned n_items);
      int unsigned made;
      int unsigned press_ms;
      int unsigned gap_ms;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_ticks.push_back(tick_type'(48'({$urandom, $urandom})));
            made++;
         end else begin
            case ($urandom_range(0, 3))
               0: press_ms = $urandom_range(0, deb_cfg);
               1: press_ms = deb_cfg + $urandom_range(0, hold_cfg);
               default: press_ms = deb_cfg + hold_cfg + $urandom_range(0, 4 * step_cfg + 10);
            endcase
            if ($urandom_range(0, 2) != 0) begin
               gap_ms = $urandom_range(0, click_cfg);
            end else begin
               gap_ms = click_cfg + $urandom_range(1, click_cfg + 50);
            end
            push_level(1'b1, press_ms, made);
            push_level(1'b0, gap_ms, made);
         end
      end
   endtask

   // Fast clicks, three ticks each, to run the series count into saturation
   task automatic gen_clicks(input int unsigned n_clicks);
      for (int unsigned i = 0; i < n_clicks; i++) begin
         cur_ms = cur_ms + 1;
         push_tick(1'b1);
         cur_ms = cur_ms + 1;
         push_tick(1'b1);
         cur_ms = cur_ms + 1;
         push_tick(1'b0);
      end
      cur_ms = cur_ms + 70000;
      push_tick(1'b0);
   endtask

   task automatic wait_drain();
      while (pending_ticks.size() != 0 || req_tvalid || expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults, sender idles lightly, receiver heavily
      send_idle = 23;
      recv_idle = 88;
      cur_ms    = 32'hFFFF_FFC0;

      // directed: debounce across the timestamp wrap, clicks, series close,
      // hold with step pulses, clear during hold, bounce shorter than debounce
      dir_tick(1'b0, 0, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 10, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 30, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 30, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 40, 5'h00, 1'b1, 8'h00, 1'b0);
      dir_tick(1'b0, 20, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 100, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 60, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b0, 30, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b0, 600, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b0, 10, 5'(1 << AckCount), 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 50, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 60, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 480, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 400, 5'h00, 1'b1, 8'h00, 1'b0);
      dir_tick(1'b1, 100, 5'h00, 1'b1, 8'h00, 1'b0);
      dir_tick(1'b1, 300, 5'h00, 1'b1, 8'hFF, 1'b0);
      dir_tick(1'b1, 0, 5'h00, 1'b1, 8'h00, 1'b0);
      dir_tick(1'b1, 10, 5'h1F, 1'b0, 8'h00, 1'b1);
      dir_tick(1'b0, 10, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 10, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b0, 5, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b1, 100, 5'h00, 1'b0, 8'h00, 1'b0);
      dir_tick(1'b0, 10, 5'h1F, 1'b1, 8'hFF, 1'b1);
      gen_sessions(20);
      wait_drain();

      // all timeouts zero, plus a write to an unused index
      write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      write_csr(3'd5 + 3'($urandom_range(0, 2)), 16'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      gen_sessions(20);
      wait_drain();

      // now the sender idles heavily, the receiver lightly
      send_idle = 88;
      recv_idle = 23;

      // series count saturation with inverted level
      write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
      gen_clicks(256);
      gen_sessions(10);
      wait_drain();

      // all timeouts at their maximum
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      cur_ms = 32'hFFFF_0000;
      gen_sessions(20);
      wait_drain();

      // no idling from here on
      send_idle = 0;
      recv_idle = 0;

      // short timeouts; only bit 0 of the invert register counts
      write_all(16'd20, 16'd150, 16'd120, 16'd40, 16'hFFFE);
      gen_sessions(20);
      wait_drain();

      // random moderate settings
      write_all(16'($urandom_range(0, 100)), 16'($urandom_range(0, 800)),
                16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)), 16'($urandom));
      cur_ms = $urandom;
      gen_sessions(20);
      wait_drain();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
